// ===== rtl/rcd_pkg.sv =====
// Package for the framed receiver with CRC-16/MODBUS check.
// Holds the defaults, frame codes, controller states, command/status structs and the CRC step.
// No dependencies.
package rcd_pkg;

  localparam int FRAME_BYTES_DEF = 38;
  localparam int CHANNELS_DEF    = 16;
  localparam int MAX_RUN         = 16;

  localparam logic [7:0]  HDR_FIRST  = 8'h55;
  localparam logic [7:0]  HDR_SECOND = 8'hAA;
  localparam logic [7:0]  TAIL_BYTE  = 8'h00;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  NIBBLE     = 8'h0F;

  // frame_status codes
  localparam logic [1:0] FS_GOOD     = 2'd0;
  localparam logic [1:0] FS_TAIL_ERR = 2'd1;
  localparam logic [1:0] FS_CRC_ERR  = 2'd2;

  typedef enum logic [2:0] {
    ST_RECV,
    ST_JUDGE,
    ST_RD_HI,
    ST_RD_LO,
    ST_LOAD
  } ctl_state_e;

  typedef struct packed {
    logic take;     // byte word accepted this cycle
    logic judge;    // check the finished frame, count it
    logic rd_hi;    // read high byte of current channel
    logic rd_lo;    // read low byte of current channel
    logic load_ch;  // load channel result into output register
  } rcd_cmd_t;

  typedef struct packed {
    logic frame_end;  // current byte is the last of the frame
    logic frame_ok;   // tail and CRC both good
    logic out_free;   // output register can take a result this cycle
    logic run_done;   // current channel is the last of the run
  } rcd_sts_t;

  // one byte of reflected CRC-16, eight bit steps
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/rcd_if.sv =====
// Channel interfaces: received byte words in, frame result words out.
// No dependencies.
interface rcd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rcd_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_status;
  logic [3:0]         channel_index;
  logic signed [15:0] channel_value;
  logic [3:0]         digital_bits;
  logic               run_last;
  logic [31:0]        good_frames;
  logic [31:0]        tail_errors;
  logic [31:0]        crc_errors;

  modport source (output valid, output frame_status, output channel_index,
                  output channel_value, output digital_bits, output run_last,
                  output good_frames, output tail_errors, output crc_errors,
                  input ready);
  modport sink   (input valid, input frame_status, input channel_index,
                  input channel_value, input digital_bits, input run_last,
                  input good_frames, input tail_errors, input crc_errors,
                  output ready);
endinterface

// ===== rtl/rcd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rcd_ram #(
  parameter int Width = 8,
  parameter int Depth = 38
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rcd_ctrl.sv =====
// Controller FSM: byte collection, frame judgment and the per-channel result sequence.
// Depends on rcd_pkg.
module rcd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rx_valid_i,
  output logic              rx_ready_o,
  input  rcd_pkg::rcd_sts_t sts_i,
  output rcd_pkg::rcd_cmd_t cmd_o
);

  rcd_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcd_pkg::ST_RECV;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rcd_pkg::ST_RECV: begin
        if (rx_valid_i && sts_i.frame_end) state_d = rcd_pkg::ST_JUDGE;
      end
      rcd_pkg::ST_JUDGE: begin
        if (sts_i.out_free) begin
          state_d = sts_i.frame_ok ? rcd_pkg::ST_RD_HI : rcd_pkg::ST_RECV;
        end
      end
      rcd_pkg::ST_RD_HI: state_d = rcd_pkg::ST_RD_LO;
      rcd_pkg::ST_RD_LO: state_d = rcd_pkg::ST_LOAD;
      rcd_pkg::ST_LOAD: begin
        if (sts_i.out_free) begin
          state_d = sts_i.run_done ? rcd_pkg::ST_RECV : rcd_pkg::ST_RD_HI;
        end
      end
      default: state_d = rcd_pkg::ST_RECV;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    rx_ready_o = 1'b0;
    unique case (state_q)
      rcd_pkg::ST_RECV: begin
        rx_ready_o = 1'b1;
        cmd_o.take = rx_valid_i;
      end
      rcd_pkg::ST_JUDGE: cmd_o.judge   = sts_i.out_free;
      rcd_pkg::ST_RD_HI: cmd_o.rd_hi   = 1'b1;
      rcd_pkg::ST_RD_LO: cmd_o.rd_lo   = 1'b1;
      rcd_pkg::ST_LOAD:  cmd_o.load_ch = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/rcd_dp.sv =====
// Datapath: frame position, running CRC, frame store, counters and output register.
// Depends on rcd_pkg and rcd_ram.
module rcd_dp #(
  parameter int FRAME_BYTES = rcd_pkg::FRAME_BYTES_DEF,
  parameter int CHANNELS    = rcd_pkg::CHANNELS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rcd_pkg::rcd_cmd_t  cmd_i,
  output rcd_pkg::rcd_sts_t  sts_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               res_ready_i,
  output logic               res_valid_o,
  output logic [1:0]         frame_status_o,
  output logic [3:0]         channel_index_o,
  output logic signed [15:0] channel_value_o,
  output logic [3:0]         digital_bits_o,
  output logic               run_last_o,
  output logic [31:0]        good_frames_o,
  output logic [31:0]        tail_errors_o,
  output logic [31:0]        crc_errors_o
);

  localparam int PosW   = $clog2(FRAME_BYTES);
  localparam int CrcEnd = FRAME_BYTES - 3;
  localparam int Run    = (CHANNELS > rcd_pkg::MAX_RUN) ? rcd_pkg::MAX_RUN : CHANNELS;

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     crc_q, crc_d;
  logic [31:0]     good_q, good_d, tail_q, tail_d, crcerr_q, crcerr_d;
  logic [3:0]      ch_q, ch_d;
  logic            out_valid_q, out_valid_d;

  logic [7:0] dig_q, crc_lo_q, crc_hi_q, tail_byte_q, hi_q;
  logic       we;
  logic [7:0] rdata;
  logic [5:0] hi_pos, lo_pos;
  logic [PosW-1:0] raddr;
  logic       tail_bad, crc_bad, load_err;
  logic [7:0] lo_byte;
  logic       frame_end, frame_ok, out_free, run_done;

  assign frame_end = (pos_q == PosW'(FRAME_BYTES - 1));
  assign tail_bad  = (tail_byte_q != rcd_pkg::TAIL_BYTE);
  assign crc_bad   = (crc_q != {crc_hi_q, crc_lo_q});
  assign frame_ok  = !tail_bad && !crc_bad;
  assign out_free  = !out_valid_q || res_ready_i;
  assign run_done  = (ch_q == 4'(Run - 1));
  assign load_err  = cmd_i.judge && !frame_ok;

  assign sts_o = '{frame_end: frame_end, frame_ok: frame_ok,
                   out_free: out_free, run_done: run_done};

  // header hunt and byte collection
  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    we    = 1'b0;
    if (cmd_i.take) begin
      if (pos_q == PosW'(0)) begin
        if (rx_byte_i == rcd_pkg::HDR_FIRST) begin
          pos_d = PosW'(1);
          crc_d = rcd_pkg::crc16_feed(rcd_pkg::CRC_INIT, rx_byte_i);
        end
      end else if (pos_q == PosW'(1)) begin
        if (rx_byte_i == rcd_pkg::HDR_SECOND) begin
          pos_d = PosW'(2);
          crc_d = rcd_pkg::crc16_feed(crc_q, rx_byte_i);
        end else if (rx_byte_i == rcd_pkg::HDR_FIRST) begin
          // repeated header start: restart with this byte
          crc_d = rcd_pkg::crc16_feed(rcd_pkg::CRC_INIT, rx_byte_i);
        end else begin
          pos_d = PosW'(0);
        end
      end else begin
        we = 1'b1;
        if (pos_q < PosW'(CrcEnd)) crc_d = rcd_pkg::crc16_feed(crc_q, rx_byte_i);
        pos_d = frame_end ? PosW'(0) : pos_q + PosW'(1);
      end
    end
  end

  // counters hold the value after this frame is counted
  always_comb begin
    good_d   = good_q;
    tail_d   = tail_q;
    crcerr_d = crcerr_q;
    if (cmd_i.judge) begin
      priority if (tail_bad) tail_d = tail_q + 32'd1;
      else if (crc_bad)      crcerr_d = crcerr_q + 32'd1;
      else                   good_d = good_q + 32'd1;
    end
  end

  always_comb begin
    ch_d = ch_q;
    if (cmd_i.judge)        ch_d = 4'd0;
    else if (cmd_i.load_ch) ch_d = ch_q + 4'd1;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid_o && res_ready_i) out_valid_d = 1'b0;
    if (load_err || cmd_i.load_ch)  out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      crc_q       <= rcd_pkg::CRC_INIT;
      good_q      <= '0;
      tail_q      <= '0;
      crcerr_q    <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      good_q      <= good_d;
      tail_q      <= tail_d;
      crcerr_q    <= crcerr_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  // trailer fields captured as they pass
  always_ff @(posedge clk_i) begin
    if (we) begin
      if (pos_q == PosW'(FRAME_BYTES - 4)) dig_q       <= rx_byte_i;
      if (pos_q == PosW'(FRAME_BYTES - 3)) crc_lo_q    <= rx_byte_i;
      if (pos_q == PosW'(FRAME_BYTES - 2)) crc_hi_q    <= rx_byte_i;
      if (pos_q == PosW'(FRAME_BYTES - 1)) tail_byte_q <= rx_byte_i;
    end
  end

  // channel bytes: big-endian pair at 2 + 2*ch, zero beyond the frame
  assign hi_pos  = {1'b0, ch_q, 1'b0} + 6'd2;
  assign lo_pos  = hi_pos + 6'd1;
  assign raddr   = cmd_i.rd_hi ? hi_pos[PosW-1:0] : lo_pos[PosW-1:0];
  assign lo_byte = ({1'b0, lo_pos} < 7'(FRAME_BYTES)) ? rdata : 8'h00;

  rcd_ram #(
    .Width (8),
    .Depth (FRAME_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pos_q),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd_hi || cmd_i.rd_lo),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_lo) hi_q <= ({1'b0, hi_pos} < 7'(FRAME_BYTES)) ? rdata : 8'h00;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load_err) begin
      frame_status_o  <= tail_bad ? rcd_pkg::FS_TAIL_ERR : rcd_pkg::FS_CRC_ERR;
      channel_index_o <= 4'd0;
      channel_value_o <= 16'sd0;
      digital_bits_o  <= 4'd0;
      run_last_o      <= 1'b1;
      good_frames_o   <= good_d;
      tail_errors_o   <= tail_d;
      crc_errors_o    <= crcerr_d;
    end else if (cmd_i.load_ch) begin
      frame_status_o  <= rcd_pkg::FS_GOOD;
      channel_index_o <= ch_q;
      channel_value_o <= $signed({hi_q, lo_byte});
      digital_bits_o  <= dig_q[3:0] & rcd_pkg::NIBBLE[3:0];
      run_last_o      <= run_done;
      good_frames_o   <= good_d;
      tail_errors_o   <= tail_d;
      crc_errors_o    <= crcerr_d;
    end
  end

  assign res_valid_o = out_valid_q;

endmodule

// ===== rtl/rc_frame_deframer_crc16_core.sv =====
// Top level of the framed receiver with CRC-16/MODBUS check.
// Depends on rcd_pkg, rcd_if, rcd_ctrl and rcd_dp.
//
//  port   | dir | word carried                       | accepted when
//  rx_i   | in  | rx_byte, one serial byte           | rx_i.valid && rx_i.ready
//  res_o  | out | status, channel, value, counters   | res_o.valid && res_o.ready
//
// The frame store writes each byte past the header in the cycle it is taken.
// At frame end the judge state checks tail and CRC, waiting while res_o stalls;
// an error result is loaded then.
// A good frame then gives each channel result by two reads of the single
// store read port and one load, waiting to load while res_o stalls.
// rx_i.ready is low after the last frame byte until the last result is loaded.
// Reset (async, active low) clears position, CRC, counters and the output valid.
module rc_frame_deframer_crc16_core #(
  parameter int FRAME_BYTES = rcd_pkg::FRAME_BYTES_DEF,
  parameter int CHANNELS    = rcd_pkg::CHANNELS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rcd_rx_if.sink    rx_i,
  rcd_res_if.source res_o
);

  rcd_pkg::rcd_cmd_t cmd;
  rcd_pkg::rcd_sts_t sts;

  rcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_i.valid),
    .rx_ready_o (rx_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rcd_dp #(
    .FRAME_BYTES (FRAME_BYTES),
    .CHANNELS    (CHANNELS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .rx_byte_i       (rx_i.rx_byte),
    .res_ready_i     (res_o.ready),
    .res_valid_o     (res_o.valid),
    .frame_status_o  (res_o.frame_status),
    .channel_index_o (res_o.channel_index),
    .channel_value_o (res_o.channel_value),
    .digital_bits_o  (res_o.digital_bits),
    .run_last_o      (res_o.run_last),
    .good_frames_o   (res_o.good_frames),
    .tail_errors_o   (res_o.tail_errors),
    .crc_errors_o    (res_o.crc_errors)
  );

endmodule

// ===== rtl/rcd_chk.sv =====
// Port-level checks on the result channel of the framed receiver.
// Depends on rcd_pkg; bound to rc_frame_deframer_crc16_core.
module rcd_chk #(
  parameter int CHANNELS = rcd_pkg::CHANNELS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [1:0]  frame_status_i,
  input logic [3:0]  channel_index_i,
  input logic [15:0] channel_value_i,
  input logic [3:0]  digital_bits_i,
  input logic        run_last_i
);

  localparam int Run = (CHANNELS > rcd_pkg::MAX_RUN) ? rcd_pkg::MAX_RUN : CHANNELS;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(frame_status_i)
      && $stable(channel_index_i) && $stable(channel_value_i) && $stable(run_last_i))
    else $error("result word changed while stalled");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && frame_status_i != rcd_pkg::FS_GOOD |-> run_last_i
      && channel_index_i == 4'd0 && channel_value_i == 16'd0 && digital_bits_i == 4'd0)
    else $error("error result is not a single zeroed word");

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && frame_status_i == rcd_pkg::FS_GOOD && run_last_i
      |-> channel_index_i == 4'(Run - 1))
    else $error("run ended on wrong channel");

  a_run_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && frame_status_i == rcd_pkg::FS_GOOD && !run_last_i
      |=> !res_valid_i || (frame_status_i == rcd_pkg::FS_GOOD
      && channel_index_i == $past(channel_index_i) + 4'd1))
    else $error("channel run broken");

endmodule

bind rc_frame_deframer_crc16_core rcd_chk #(
  .CHANNELS (CHANNELS)
) u_rcd_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .frame_status_i  (res_o.frame_status),
  .channel_index_i (res_o.channel_index),
  .channel_value_i (res_o.channel_value),
  .digital_bits_i  (res_o.digital_bits),
  .run_last_i      (res_o.run_last)
);

// ===== tb/tb_top.sv =====
// Self-checking bench for rc_frame_deframer_crc16_core: random and directed byte streams,
// results checked against an in-bench frame decoder with its own CRC-16/MODBUS.
// Depends on rcd_pkg, rcd_if and the core.
module tb_top;

  localparam int FB           = rcd_pkg::FRAME_BYTES_DEF;
  localparam int NCH          = rcd_pkg::CHANNELS_DEF;
  localparam int RANDOM_ITEMS = 20;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 100;

  typedef enum int {FLAW_NONE, FLAW_TAIL, FLAW_CRC, FLAW_BOTH} flaw_e;

  typedef struct {
    logic [1:0]         status;
    logic [3:0]         chan;
    logic signed [15:0] value;
    logic [3:0]         dig;
    logic               last;
    logic [31:0]        good;
    logic [31:0]        tail;
    logic [31:0]        crc;
  } frame_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rcd_rx_if  rx_if ();
  rcd_res_if res_if ();

  rc_frame_deframer_crc16_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  always #4 clk_i = ~clk_i;

  frame_result_t expected_q[$];
  int            fail_count  = 0;
  bit            src_steady  = 1'b0;
  bit            sink_steady = 1'b0;

  // decoder state
  int          dec_pos = 0;
  logic [7:0]  dec_store [64];
  logic [15:0] dec_crc = rcd_pkg::CRC_INIT;
  logic [31:0] dec_good = '0;
  logic [31:0] dec_tail = '0;
  logic [31:0] dec_crc_err = '0;

  logic [7:0]  frame_buf [FB];

  function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ rcd_pkg::CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // bytes past the frame read as zero
  function automatic logic [7:0] dec_byte(input int idx);
    if (idx < FB && idx < 64) begin
      return dec_store[idx];
    end
    return 8'h00;
  endfunction

  function automatic void push_result(input logic [1:0] status, input logic [3:0] chan,
                                      input logic [15:0] value, input logic [3:0] dig,
                                      input logic last);
    frame_result_t r;
    r.status = status;
    r.chan   = chan;
    r.value  = value;
    r.dig    = dig;
    r.last   = last;
    r.good   = dec_good;
    r.tail   = dec_tail;
    r.crc    = dec_crc_err;
    expected_q.push_back(r);
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    logic [15:0] rx_crc;
    int          run;
    if (dec_pos == 0) begin
      if (b == rcd_pkg::HDR_FIRST) begin
        dec_store[0] = b;
        dec_crc      = modbus_crc_byte(rcd_pkg::CRC_INIT, b);
        dec_pos      = 1;
      end
    end else if (dec_pos == 1) begin
      if (b == rcd_pkg::HDR_SECOND) begin
        dec_store[1] = b;
        dec_crc      = modbus_crc_byte(dec_crc, b);
        dec_pos      = 2;
      end else if (b == rcd_pkg::HDR_FIRST) begin
        // another header start: restart on this byte
        dec_store[0] = b;
        dec_crc      = modbus_crc_byte(rcd_pkg::CRC_INIT, b);
      end else begin
        dec_pos = 0;
        dec_crc = rcd_pkg::CRC_INIT;
      end
    end else begin
      if (dec_pos < 64) dec_store[dec_pos] = b;
      if (dec_pos < FB - 3) dec_crc = modbus_crc_byte(dec_crc, b);
      dec_pos++;
      if (dec_pos >= FB) begin
        dec_pos = 0;
        rx_crc  = {dec_byte(FB - 2), dec_byte(FB - 3)};
        // tail checked first, CRC skipped on a bad tail
        if (dec_byte(FB - 1) != rcd_pkg::TAIL_BYTE) begin
          dec_tail++;
          push_result(rcd_pkg::FS_TAIL_ERR, 4'd0, 16'd0, 4'd0, 1'b1);
        end else if (dec_crc != rx_crc) begin
          dec_crc_err++;
          push_result(rcd_pkg::FS_CRC_ERR, 4'd0, 16'd0, 4'd0, 1'b1);
        end else begin
          dec_good++;
          run = (NCH > rcd_pkg::MAX_RUN) ? rcd_pkg::MAX_RUN : NCH;
          for (int i = 0; i < run; i++) begin
            push_result(rcd_pkg::FS_GOOD, i[3:0], {dec_byte(2 + 2 * i), dec_byte(3 + 2 * i)},
                        4'(dec_byte(FB - 4) & rcd_pkg::NIBBLE), (i + 1 == run));
          end
        end
        dec_crc = rcd_pkg::CRC_INIT;
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    decode_byte(b);
  endtask

  task automatic hold_until_drained();
    rx_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
  endtask

  task automatic fill_random_channels();
    for (int k = 2; k < FB - 4; k++) begin
      frame_buf[k] = 8'($urandom_range(0, 255));
    end
  endtask

  task automatic set_channel(input int idx, input logic [15:0] v);
    frame_buf[2 + 2 * idx] = v[15:8];
    frame_buf[3 + 2 * idx] = v[7:0];
  endtask

  task automatic seal_frame(input logic [7:0] dig, input flaw_e flaw);
    logic [15:0] c;
    logic [15:0] flip;
    frame_buf[0]      = rcd_pkg::HDR_FIRST;
    frame_buf[1]      = rcd_pkg::HDR_SECOND;
    frame_buf[FB - 4] = dig;
    c = rcd_pkg::CRC_INIT;
    for (int k = 0; k < FB - 3; k++) begin
      c = modbus_crc_byte(c, frame_buf[k]);
    end
    if (flaw == FLAW_CRC || flaw == FLAW_BOTH) begin
      flip = 16'($urandom_range(1, 16'hFFFF));
      c    = c ^ flip;
    end
    frame_buf[FB - 3] = c[7:0];
    frame_buf[FB - 2] = c[15:8];
    if (flaw == FLAW_TAIL || flaw == FLAW_BOTH) begin
      frame_buf[FB - 1] = 8'($urandom_range(1, 255));
    end else begin
      frame_buf[FB - 1] = rcd_pkg::TAIL_BYTE;
    end
  endtask

  task automatic send_frame_from(input int start);
    for (int k = start; k < FB; k++) begin
      send_byte(frame_buf[k]);
    end
  endtask

  task automatic test_good_frames();
    fill_random_channels();
    set_channel(0, 16'h8000);
    set_channel(1, 16'h7FFF);
    set_channel(2, 16'h0000);
    set_channel(3, 16'hFFFF);
    set_channel(NCH - 1, 16'h8001);
    seal_frame(8'hFF, FLAW_NONE);
    send_frame_from(0);
    // header pattern inside the payload must not resync
    for (int i = 0; i < NCH; i++) set_channel(i, 16'h55AA);
    seal_frame(8'hF0, FLAW_NONE);
    send_frame_from(0);
    fill_random_channels();
    seal_frame(8'h0A, FLAW_NONE);
    send_frame_from(0);
  endtask

  task automatic test_header_hunt();
    send_byte(rcd_pkg::HDR_SECOND);
    send_byte(8'h00);
    send_byte(rcd_pkg::HDR_FIRST);
    send_byte(rcd_pkg::HDR_FIRST);
    fill_random_channels();
    seal_frame(8'h05, FLAW_NONE);
    send_frame_from(0);
    // broken header, then a stray second header byte while hunting
    send_byte(rcd_pkg::HDR_FIRST);
    send_byte(8'h13);
    send_byte(rcd_pkg::HDR_SECOND);
    send_byte(rcd_pkg::HDR_FIRST);
    send_byte(8'hFF);
    fill_random_channels();
    seal_frame(8'h3C, FLAW_NONE);
    send_frame_from(0);
  endtask

  task automatic test_frame_errors();
    fill_random_channels();
    seal_frame(8'h11, FLAW_TAIL);
    send_frame_from(0);
    fill_random_channels();
    seal_frame(8'h22, FLAW_CRC);
    send_frame_from(0);
    fill_random_channels();
    seal_frame(8'h33, FLAW_BOTH);
    send_frame_from(0);
    fill_random_channels();
    seal_frame(8'h4B, FLAW_NONE);
    send_frame_from(0);
  endtask

  task automatic test_random_traffic();
    int   sent;
    int   pick;
    int   n;
    bit   paused;
    logic [7:0] junk;
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) src_steady = ~src_steady;
      if ($urandom_range(0, 3) == 0) sink_steady = ~sink_steady;
      pick = $urandom_range(0, 11);
      fill_random_channels();
      case (pick)
        7: seal_frame(8'($urandom_range(0, 255)), FLAW_TAIL);
        8: seal_frame(8'($urandom_range(0, 255)), FLAW_CRC);
        9: seal_frame(8'($urandom_range(0, 255)), FLAW_BOTH);
        default: seal_frame(8'($urandom_range(0, 255)), FLAW_NONE);
      endcase
      if (pick == 10) begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
      end else if (pick == 11) begin
        if ($urandom_range(0, 1) == 0) begin
          n = $urandom_range(1, 4);
          repeat (n) send_byte(rcd_pkg::HDR_FIRST);
        end else begin
          send_byte(rcd_pkg::HDR_FIRST);
          do junk = 8'($urandom_range(0, 255));
          while (junk == rcd_pkg::HDR_FIRST || junk == rcd_pkg::HDR_SECOND);
          send_byte(junk);
        end
      end
      send_frame_from(0);
      sent += FB;
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    frame_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got status %h chan %h value %h",
                 $time, res_if.frame_status, res_if.channel_index, res_if.channel_value);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("frame_status", 32'(want.status), 32'(res_if.frame_status));
        check_field("channel_index", 32'(want.chan), 32'(res_if.channel_index));
        check_field("channel_value", 32'(want.value), 32'(res_if.channel_value));
        check_field("digital_bits", 32'(want.dig), 32'(res_if.digital_bits));
        check_field("run_last", 32'(want.last), 32'(res_if.run_last));
        check_field("good_frames", want.good, res_if.good_frames);
        check_field("tail_errors", want.tail, res_if.tail_errors);
        check_field("crc_errors", want.crc, res_if.crc_errors);
      end
    end
  end

  initial begin : result_sink
    int stall;
    res_if.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      stall = sink_steady ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_good_frames();
    hold_until_drained();
    test_header_hunt();
    test_frame_errors();
    hold_until_drained();
    test_random_traffic();
    hold_until_drained();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, expected_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rcd_pkg.sv
rtl/rcd_if.sv
rtl/rcd_ram.sv
rtl/rcd_ctrl.sv
rtl/rcd_dp.sv
rtl/rc_frame_deframer_crc16_core.sv
rtl/rcd_chk.sv
tb/tb_top.sv
